/* rtl/eav_pkg.sv */
package eav_pkg;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_DEL    = 8'h7f;

   typedef enum logic [4:0] {
      PH_LOCAL  = 5'b00001,
      PH_QUOTED = 5'b00010,
      PH_ESCAPE = 5'b00100,
      PH_AFTERQ = 5'b01000,
      PH_DOMAIN = 5'b10000
   } phase_type;

   typedef struct packed {
      logic is_quote;
      logic is_at;
      logic is_dot;
      logic is_bslash;
      logic is_space;
      logic ctl_high;
      logic special;
   } char_class_type;

   // ( ) < > @ , ; : \ " [ ]
   function automatic logic is_special(input logic [7:0] b);
      logic hit;
      case (b)
         8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c,
         8'h3b, 8'h3a, 8'h5c, 8'h22, 8'h5b, 8'h5d: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

/* rtl/email_address_validator.sv */
// Channel  Direction  Ports                                   Moves
// req      in         req_valid req_ready req_ch              one byte or end marker per item
//                     req_end_of_address
// rsp      out        rsp_valid rsp_ready rsp_address_valid   one verdict per end marker
//
// One item per cycle unless an end marker stalls: input register, then one state update.
// A verdict enters the output register as its end marker leaves the input register.
// A held verdict stalls only a following end marker; byte items keep flowing.
// Synchronous reset clears the parser state and both valid flags.
module email_address_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_address,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_address_valid
);
   import eav_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     ch_ff;
   logic           end_ff;
   logic           out_valid_ff, out_valid_in;
   logic           out_ok_ff;
   logic           advance;
   logic           verdict;
   char_class_type cls;

   // a byte item never needs the output slot
   assign advance   = in_valid_ff && (!end_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid         = out_valid_ff;
   assign rsp_address_valid = out_ok_ff;

   eav_char_class u_class (
      .ch  (ch_ff),
      .cls (cls)
   );

   eav_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .end_of_address (end_ff),
      .cls            (cls),
      .verdict        (verdict)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance && end_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ch_ff  <= req_ch;
         end_ff <= req_end_of_address;
      end
      if (advance && end_ff) begin
         out_ok_ff <= verdict;
      end
   end

`ifndef ASSERT_OFF
   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_ready)
      else $error("input register overwritten while blocked");

   a_blocked_only_by_end: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> end_ff && out_valid_ff && !rsp_ready)
      else $error("item stalled without a held verdict");

   a_verdict_loaded: assert property (@(posedge clock) disable iff (reset)
      advance && end_ff |=> out_valid_ff && out_ok_ff == $past(verdict))
      else $error("verdict not loaded into the output register");
`endif

endmodule

/* rtl/eav_char_class.sv */
module eav_char_class (
   input  logic [7:0]              ch,
   output eav_pkg::char_class_type cls
);
   import eav_pkg::*;

   always_comb begin
      cls.is_quote  = (ch == CH_QUOTE);
      cls.is_at     = (ch == CH_AT);
      cls.is_dot    = (ch == CH_DOT);
      cls.is_bslash = (ch == CH_BSLASH);
      cls.is_space  = (ch == CH_SPACE);
      cls.ctl_high  = (ch <= CH_SPACE) || (ch >= CH_DEL);
      cls.special   = is_special(ch);
   end

endmodule

/* rtl/eav_parser.sv */
module eav_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    end_of_address,
   input  eav_pkg::char_class_type cls,
   output logic                    verdict
);
   import eav_pkg::*;

   phase_type phase_ff, phase_in;
   logic      part_empty_ff, part_empty_in;
   logic      prev_dot_ff, prev_dot_in;
   logic      dom_dot_ff, dom_dot_in;
   logic      rejected_ff, rejected_in;

   assign verdict = !rejected_ff && (phase_ff == PH_DOMAIN) && !part_empty_ff && dom_dot_ff;

   always_comb begin
      phase_in      = phase_ff;
      part_empty_in = part_empty_ff;
      prev_dot_in   = prev_dot_ff;
      dom_dot_in    = dom_dot_ff;
      rejected_in   = rejected_ff;
      if (end_of_address) begin
         // verdict taken, start over
         phase_in      = PH_LOCAL;
         part_empty_in = 1'b1;
         prev_dot_in   = 1'b0;
         dom_dot_in    = 1'b0;
         rejected_in   = 1'b0;
      end else if (!rejected_ff) begin
         unique case (phase_ff)
            PH_LOCAL: begin
               if (cls.is_quote && (part_empty_ff || prev_dot_ff)) begin
                  phase_in      = PH_QUOTED;
                  part_empty_in = 1'b0;
                  prev_dot_in   = 1'b0;
               end else if (cls.is_at) begin
                  if (part_empty_ff || prev_dot_ff) begin
                     rejected_in = 1'b1;
                  end else begin
                     phase_in      = PH_DOMAIN;
                     part_empty_in = 1'b1;
                     prev_dot_in   = 1'b0;
                  end
               end else if (cls.ctl_high || cls.special) begin
                  rejected_in = 1'b1;
               end else begin
                  part_empty_in = 1'b0;
                  prev_dot_in   = cls.is_dot;
               end
            end
            PH_QUOTED: begin
               if (cls.is_quote) begin
                  phase_in = PH_AFTERQ;
               end else if (cls.is_bslash) begin
                  phase_in = PH_ESCAPE;
               end else if (cls.ctl_high) begin
                  rejected_in = 1'b1;
               end
            end
            PH_ESCAPE: begin
               if (!cls.is_space && cls.ctl_high) begin
                  rejected_in = 1'b1;
               end else begin
                  phase_in = PH_QUOTED;
               end
            end
            PH_AFTERQ: begin
               if (cls.is_at) begin
                  phase_in      = PH_DOMAIN;
                  part_empty_in = 1'b1;
                  prev_dot_in   = 1'b0;
               end else if (cls.is_dot) begin
                  phase_in    = PH_LOCAL;
                  prev_dot_in = 1'b1;
               end else begin
                  rejected_in = 1'b1;
               end
            end
            PH_DOMAIN: begin
               if (cls.is_dot && (part_empty_ff || prev_dot_ff)) begin
                  rejected_in = 1'b1;
               end else if (cls.ctl_high || cls.special) begin
                  // a dot is never special or a control byte, so the old dot mark survives here
                  rejected_in = 1'b1;
                  dom_dot_in  = dom_dot_ff | cls.is_dot;
               end else begin
                  dom_dot_in    = dom_dot_ff | cls.is_dot;
                  part_empty_in = 1'b0;
                  prev_dot_in   = cls.is_dot;
               end
            end
            default: begin
               rejected_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LOCAL;
         part_empty_ff <= 1'b1;
         prev_dot_ff   <= 1'b0;
         dom_dot_ff    <= 1'b0;
         rejected_ff   <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         part_empty_ff <= part_empty_in;
         prev_dot_ff   <= prev_dot_in;
         dom_dot_ff    <= dom_dot_in;
         rejected_ff   <= rejected_in;
      end
   end

`ifndef ASSERT_OFF
   a_reject_sticky: assert property (@(posedge clock) disable iff (reset)
      rejected_ff && !(step && end_of_address) |=> rejected_ff)
      else $error("rejection cleared before end of address");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      step && end_of_address |=> phase_ff == PH_LOCAL && part_empty_ff && !rejected_ff)
      else $error("parser did not restart after end of address");

   a_dom_dot_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DOMAIN && dom_dot_ff |-> !part_empty_ff)
      else $error("domain dot seen in an empty domain");

   a_dot_outside_domain: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_DOMAIN |-> !dom_dot_ff)
      else $error("domain dot mark set outside the domain");
`endif

endmodule

/* tb/tb_email_address_validator.sv */
module tb_email_address_validator;
   timeunit 1ns;
   timeprecision 1ps;

   import eav_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEMS_PER_PHASE = 131;

   typedef struct {
      logic [7:0] ch;
      logic       eoa;
   } req_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch = 8'h00;
   logic       req_end_of_address = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_address_valid;

   req_item_type pending_q[$];
   logic         verdict_q[$];
   req_item_type next_item;
   logic       exp_verdict;
   int         items_pushed = 0;
   int         mismatch_cnt = 0;
   int         idle_cycles = 0;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         idle_tab[4] = '{0, 61, 0, 8};
   int         stall_tab[4] = '{0, 0, 61, 8};

   // parser state mirrored from the block
   phase_type  ps_phase;
   logic       ps_part_empty;
   logic       ps_prev_dot;
   logic       ps_dom_dot;
   logic       ps_rejected;

   email_address_validator uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_ch             (req_ch),
      .req_end_of_address (req_end_of_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_address_valid  (rsp_address_valid)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic in_specials(input logic [7:0] b);
      case (b)
         "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "[", "]": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic ctl_or_high(input logic [7:0] b);
      return (b <= CH_SPACE) || (b >= CH_DEL);
   endfunction

   function automatic void clear_parser();
      ps_phase      = PH_LOCAL;
      ps_part_empty = 1'b1;
      ps_prev_dot   = 1'b0;
      ps_dom_dot    = 1'b0;
      ps_rejected   = 1'b0;
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      case (ps_phase)
         PH_LOCAL: begin
            if (b == CH_QUOTE && (ps_part_empty || ps_prev_dot)) begin
               ps_phase      = PH_QUOTED;
               ps_part_empty = 1'b0;
               ps_prev_dot   = 1'b0;
            end else if (b == CH_AT) begin
               if (ps_part_empty || ps_prev_dot) begin
                  ps_rejected = 1'b1;
               end else begin
                  ps_phase      = PH_DOMAIN;
                  ps_part_empty = 1'b1;
                  ps_prev_dot   = 1'b0;
               end
            end else if (ctl_or_high(b) || in_specials(b)) begin
               ps_rejected = 1'b1;
            end else begin
               ps_part_empty = 1'b0;
               ps_prev_dot   = (b == CH_DOT);
            end
         end
         PH_QUOTED: begin
            if (b == CH_QUOTE) ps_phase = PH_AFTERQ;
            else if (b == CH_BSLASH) ps_phase = PH_ESCAPE;
            else if (ctl_or_high(b)) ps_rejected = 1'b1;
         end
         PH_ESCAPE: begin
            if (b != CH_SPACE && ctl_or_high(b)) ps_rejected = 1'b1;
            else ps_phase = PH_QUOTED;
         end
         PH_AFTERQ: begin
            if (b == CH_AT) begin
               ps_phase      = PH_DOMAIN;
               ps_part_empty = 1'b1;
               ps_prev_dot   = 1'b0;
            end else if (b == CH_DOT) begin
               ps_phase    = PH_LOCAL;
               ps_prev_dot = 1'b1;
            end else begin
               ps_rejected = 1'b1;
            end
         end
         PH_DOMAIN: begin
            if (b == CH_DOT && (ps_part_empty || ps_prev_dot)) begin
               ps_rejected = 1'b1;
            end else if (ctl_or_high(b) || in_specials(b)) begin
               ps_rejected = 1'b1;
            end else begin
               if (b == CH_DOT) ps_dom_dot = 1'b1;
               ps_part_empty = 1'b0;
               ps_prev_dot   = (b == CH_DOT);
            end
         end
         default: ps_rejected = 1'b1;
      endcase
   endfunction

   function automatic void predict_item(input logic [7:0] b, input logic eoa);
      if (eoa) begin
         verdict_q.push_back(!ps_rejected && ps_phase == PH_DOMAIN && !ps_part_empty &&
                             ps_dom_dot);
         clear_parser();
      end else if (!ps_rejected) begin
         parse_byte(b);
      end
   endfunction

   task automatic push_byte(input logic [7:0] b);
      pending_q.push_back('{ch: b, eoa: 1'b0});
      items_pushed++;
   endtask

   task automatic push_end();
      // byte lane is don't-care on the end marker, so randomize it
      pending_q.push_back('{ch: 8'($urandom_range(255)), eoa: 1'b1});
      items_pushed++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
      push_end();
   endtask

   function automatic logic [7:0] atom_char();
      logic [7:0] b;
      do b = 8'($urandom_range(33, 126)); while (in_specials(b));
      return b;
   endfunction

   function automatic logic [7:0] quoted_char();
      logic [7:0] b;
      if ($urandom_range(99) < 10) return 8'($urandom_range(255));
      do b = 8'($urandom_range(33, 126)); while (b == CH_QUOTE || b == CH_BSLASH);
      return b;
   endfunction

   function automatic logic [7:0] tricky_char();
      case ($urandom_range(6))
         0: return CH_DOT;
         1: return CH_QUOTE;
         2: return CH_AT;
         3: return CH_BSLASH;
         4: return CH_SPACE;
         5: return "[";
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic gen_address();
      logic [7:0] addr_q[$];
      int         kind;
      int         nseg;
      int         len;
      int         pos;
      kind = $urandom_range(99);
      if (kind < 10) begin
         len = $urandom_range(8);
         repeat (len) addr_q.push_back(8'($urandom_range(255)));
      end else begin
         nseg = $urandom_range(1, 3);
         for (int s = 0; s < nseg; s++) begin
            if (s > 0) addr_q.push_back(CH_DOT);
            if ($urandom_range(99) < 30) begin
               addr_q.push_back(CH_QUOTE);
               len = $urandom_range(4);
               repeat (len) begin
                  if ($urandom_range(99) < 25) begin
                     addr_q.push_back(CH_BSLASH);
                     addr_q.push_back($urandom_range(99) < 80 ? 8'($urandom_range(32, 126))
                                                              : 8'($urandom_range(255)));
                  end else begin
                     addr_q.push_back(quoted_char());
                  end
               end
               addr_q.push_back(CH_QUOTE);
            end else begin
               len = $urandom_range(1, 4);
               repeat (len) addr_q.push_back(atom_char());
            end
         end
         addr_q.push_back(CH_AT);
         nseg = $urandom_range(1, 3);
         for (int s = 0; s < nseg; s++) begin
            if (s > 0) addr_q.push_back(CH_DOT);
            len = $urandom_range(1, 4);
            repeat (len) addr_q.push_back(atom_char());
         end
         if ($urandom_range(99) < 15) addr_q.push_back(CH_DOT);
         // break a share of the well-formed addresses
         if (kind < 40) begin
            pos = $urandom_range(addr_q.size() - 1);
            case ($urandom_range(3))
               0: addr_q[pos] = tricky_char();
               1: addr_q.delete(pos);
               2: addr_q.insert(pos, tricky_char());
               default: while (addr_q.size() > pos) void'(addr_q.pop_back());
            endcase
         end
      end
      foreach (addr_q[i]) push_byte(addr_q[i]);
      push_end();
   endtask

   // driver: present items from the queue, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_item(req_ch, req_end_of_address);
         end
         if (!req_valid || req_ready) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = pending_q.pop_front();
               req_valid          <= 1'b1;
               req_ch             <= next_item.ch;
               req_end_of_address <= next_item.eoa;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: stall at random, compare each verdict with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("ERROR: unexpected verdict %0b at %0t", rsp_address_valid, $realtime);
            end else begin
               exp_verdict = verdict_q.pop_front();
               if (rsp_address_valid !== exp_verdict) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("ERROR: address_valid expected %0b actual %0b at %0t",
                              exp_verdict, rsp_address_valid, $realtime);
               end
            end
         end
      end
   end

   // watchdog: count cycles with work outstanding and no handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (pending_q.size() == 0 && !req_valid && verdict_q.size() == 0)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int target;
      clear_parser();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_tab[ph];
         stall_pct     = stall_tab[ph];
         if (ph == 0) begin
            push_end();                 // empty address
            push_text("a@b.c");
            push_text("\"\\ \"@d.e");   // escaped space inside quotes
            push_byte(8'h00);           // zero byte is just a control byte
            push_end();
            push_byte(8'hff);
            push_end();
            push_text(".a@b.");         // leading local dot, trailing domain dot
         end
         target = items_pushed + ITEMS_PER_PHASE;
         while (items_pushed < target) gen_address();
         while (pending_q.size() != 0 || req_valid || verdict_q.size() != 0) @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("ERROR: %0d mismatches, %0d verdicts missing", mismatch_cnt, verdict_q.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
